>>> sv/i2cms_pkg.sv
// shared types, constants and sequence lengths for the i2c master bit sequencer
package i2cms_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int QCNT_W      = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    CMD_IDLE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5,
    CMD_ACK      = 3'd6,
    CMD_NACK     = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [QCNT_W-1:0]    qcnt;
    logic [1:0]           phase;
    logic [BYTE_BITS-1:0] shift;
    logic                 scl;
    logic                 sda;
    logic                 drive;
    logic [BYTE_BITS-1:0] rd;
    logic                 ack;
  } state_t;

  typedef struct packed {
    logic done;
    logic rej;
  } flags_t;

  localparam logic [QCNT_W-1:0] WRITE_LAST_Q = QCNT_W'(3 * BYTE_BITS - 1);
  localparam logic [QCNT_W-1:0] READ_LAST_Q  = QCNT_W'(2 * BYTE_BITS - 1);

  function automatic logic [QCNT_W-1:0] seq_last(input cmd_t c);
    logic [QCNT_W-1:0] res;
    unique case (c)
      CMD_START: res = QCNT_W'(3);
      CMD_STOP:  res = QCNT_W'(1);
      CMD_WRITE: res = WRITE_LAST_Q;
      CMD_READ:  res = READ_LAST_Q;
      default:   res = QCNT_W'(2);
    endcase
    return res;
  endfunction

endpackage

>>> sv/i2c_master_bit_sequencer.sv
// i2c master bit sequencer top level with stream ports and result register
// Takes one transaction per clock: a tick ends the current bus quantum, any
// other action starts a command when idle and is flagged rejected when busy.
// The state update is a single combinational pass from the accepted
// transaction into the state registers; the result is held in an output
// register and appears in the cycle after acceptance. in_tready is high whenever
// that register is empty or being taken, so with a ready sink the block takes
// one transaction every cycle. Pins reported are those for the coming quantum.
module i2c_master_bit_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // write_byte [7:0], sda_in [8], zero pad [15:9]
  input  logic [i2cms_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action [2:0]
  input  logic [2:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // scl [0], sda_level [1], sda_drive [2], busy_res [3], done_res [4],
  // rejected [5], read_data [13:6], ack_bit [14], zero pad [15]
  output logic [i2cms_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import i2cms_pkg::*;

  state_t                 st_r;
  state_t                 st_nxt;
  flags_t                 flags;
  logic                   in_acc;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  i2cms_step u_step (
    .cur        (st_r),
    .action     (cmd_t'(in_tuser)),
    .write_byte (in_tdata[BYTE_BITS-1:0]),
    .sda_in     (in_tdata[BYTE_BITS]),
    .nxt        (st_nxt),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cmd   <= CMD_IDLE;
      st_r.qcnt  <= '0;
      st_r.phase <= 2'd0;
      st_r.shift <= '0;
      st_r.scl   <= 1'b1;
      st_r.sda   <= 1'b1;
      st_r.drive <= 1'b1;
      st_r.rd    <= '0;
      st_r.ack   <= 1'b0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_acc) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {1'b0, st_nxt.ack, st_nxt.rd, flags.rej, flags.done,
                      (st_nxt.cmd != CMD_IDLE), st_nxt.drive, st_nxt.sda, st_nxt.scl};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cmd != CMD_IDLE |-> st_r.qcnt <= WRITE_LAST_Q)
    else $error("quantum count beyond longest sequence");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cmd == CMD_IDLE |-> (st_r.qcnt == '0 && st_r.phase == 2'd0))
    else $error("idle with quantum count left over");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd_t'(in_tuser) != CMD_IDLE && st_r.cmd != CMD_IDLE) |=> $stable(st_r))
    else $error("rejected command changed the sequence state");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[4]) |-> !out_tdata_r[3])
    else $error("done reported while still busy");

  a_read_released: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cmd == CMD_READ || st_r.cmd == CMD_WAIT_ACK) |-> !st_r.drive)
    else $error("sda driven during a read phase");

endmodule

>>> sv/i2cms_step.sv
// next-state logic: one command or one tick applied to the sequencer state
module i2cms_step (
  input  i2cms_pkg::state_t                  cur,
  input  i2cms_pkg::cmd_t                    action,
  input  logic [i2cms_pkg::BYTE_BITS-1:0]    write_byte,
  input  logic                               sda_in,
  output i2cms_pkg::state_t                  nxt,
  output i2cms_pkg::flags_t                  flags
);
  import i2cms_pkg::*;

  logic [QCNT_W-1:0]    q_inc;
  logic [1:0]           phase_inc;
  logic [BYTE_BITS-1:0] shift_smp;
  logic                 finish;

  always_comb begin
    q_inc     = cur.qcnt + QCNT_W'(1);
    phase_inc = (cur.phase == 2'd2) ? 2'd0 : cur.phase + 2'd1;
    finish    = (cur.qcnt == seq_last(cur.cmd));
    if (cur.cmd == CMD_READ && !cur.qcnt[0]) begin
      shift_smp = {cur.shift[BYTE_BITS-2:0], sda_in};
    end else begin
      shift_smp = cur.shift;
    end
  end

  always_comb begin
    nxt        = cur;
    flags.done = 1'b0;
    flags.rej  = 1'b0;
    if (action != CMD_IDLE) begin
      if (cur.cmd != CMD_IDLE) begin
        flags.rej = 1'b1;
      end else begin
        nxt.cmd   = action;
        nxt.qcnt  = '0;
        nxt.phase = 2'd0;
        nxt.shift = '0;
        unique case (action)
          CMD_START: begin
            nxt.drive = 1'b1;
            nxt.sda   = 1'b1;
          end
          CMD_STOP, CMD_ACK: begin
            nxt.drive = 1'b1;
            nxt.sda   = 1'b0;
          end
          CMD_WRITE: begin
            nxt.drive = 1'b1;
            nxt.sda   = write_byte[BYTE_BITS-1];
            nxt.shift = write_byte;
          end
          CMD_READ: begin
            nxt.drive = 1'b0;
            nxt.sda   = 1'b1;
            nxt.scl   = 1'b1;
          end
          CMD_WAIT_ACK: begin
            nxt.drive = 1'b0;
            nxt.sda   = 1'b1;
          end
          CMD_NACK: begin
            nxt.drive = 1'b1;
            nxt.sda   = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (cur.cmd != CMD_IDLE) begin
      nxt.shift = shift_smp;
      if (cur.cmd == CMD_WAIT_ACK && cur.qcnt == QCNT_W'(1)) begin
        nxt.ack = sda_in;
      end
      if (finish) begin
        if (cur.cmd == CMD_STOP || cur.cmd == CMD_ACK) begin
          nxt.sda = 1'b1;
        end
        if (cur.cmd == CMD_READ) begin
          nxt.rd = shift_smp;
        end
        nxt.cmd    = CMD_IDLE;
        nxt.qcnt   = '0;
        nxt.phase  = 2'd0;
        flags.done = 1'b1;
      end else begin
        nxt.qcnt  = q_inc;
        nxt.phase = phase_inc;
        unique case (cur.cmd)
          CMD_START: begin
            if (q_inc == QCNT_W'(1)) begin
              nxt.scl = 1'b1;
            end else if (q_inc == QCNT_W'(2)) begin
              nxt.sda = 1'b0;
            end else begin
              nxt.scl = 1'b0;
            end
          end
          CMD_STOP: nxt.scl = 1'b1;
          CMD_WRITE: begin
            unique case (phase_inc)
              2'd0: begin
                nxt.drive = 1'b1;
                nxt.sda   = shift_smp[BYTE_BITS-1];
              end
              2'd1: nxt.scl = 1'b1;
              default: begin
                nxt.scl   = 1'b0;
                if (q_inc == WRITE_LAST_Q) begin
                  nxt.sda = 1'b1;
                end
                nxt.shift = {shift_smp[BYTE_BITS-2:0], 1'b0};
              end
            endcase
          end
          CMD_READ: nxt.scl = ~q_inc[0];
          default: begin
            nxt.scl = (q_inc == QCNT_W'(1));
          end
        endcase
      end
    end
  end

endmodule
